[sv/skip_pointer_filter_table_assert.svh]
// Assertion macros used by the top-level file to check its own behavior.
`ifndef SKIP_POINTER_FILTER_TABLE_ASSERT_SVH
`define SKIP_POINTER_FILTER_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define SPFT_ASSERT_SAME(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("spft assertion failed");
`define SPFT_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("spft assertion failed");
`else
`define SPFT_ASSERT_SAME(label, ck, rn, ante, cons)
`define SPFT_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

[sv/spft_pkg.sv]
package spft_pkg;

    localparam int ID_W = 10;

    localparam logic [1:0] CMD_QUERY  = 2'd0;
    localparam logic [1:0] CMD_MASK   = 2'd1;
    localparam logic [1:0] CMD_UNMASK = 2'd2;

    localparam logic [ID_W-1:0] LIMIT_RESET = 10'd1023;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic look_id;
        logic look_prev;
        logic decide;
        logic walk_start;
        logic walk_step;
        logic scan_start;
        logic scan_step;
    } spft_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic walk_go;
        logic walk_more;
        logic scan_skip;
        logic scan_done;
    } spft_stat_t;

endpackage

[sv/spft_ctrl.sv]
module spft_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  spft_pkg::spft_stat_t  stat,
    output spft_pkg::spft_cmd_t   cmd,
    output logic                  busy,
    output logic                  done
);
    import spft_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK_ID,
        S_LOOK_PREV,
        S_DECIDE,
        S_WALK_START,
        S_WALK,
        S_SCAN_START,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOK_ID;
                end
            end
            S_LOOK_ID:
            begin
                cmd.look_id = 1'b1;
                state_next  = S_LOOK_PREV;
            end
            S_LOOK_PREV:
            begin
                cmd.look_prev = 1'b1;
                state_next    = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.walk_go ? S_WALK_START : S_SCAN_START;
            end
            S_WALK_START:
            begin
                cmd.walk_start = 1'b1;
                state_next     = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (!stat.walk_more)
                begin
                    state_next = S_SCAN_START;
                end
            end
            S_SCAN_START:
            begin
                cmd.scan_start = 1'b1;
                if (stat.scan_skip)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

[sv/spft_datapath.sv]
module spft_datapath #(
    parameter int MAX_ID = 1023
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  spft_pkg::spft_cmd_t          cmd,
    output spft_pkg::spft_stat_t         stat,
    input  logic [1:0]                   command,
    input  logic [spft_pkg::ID_W-1:0]    item_id,
    input  logic                         cfg_wr_en,
    input  logic [spft_pkg::ID_W-1:0]    cfg_wr_data,
    output logic                         status,
    output logic                         is_masked,
    output logic [spft_pkg::ID_W-1:0]    next_unmasked,
    output logic [spft_pkg::ID_W-1:0]    next_masked,
    output logic [spft_pkg::ID_W-1:0]    masked_count
);
    import spft_pkg::*;

    localparam int AW = $clog2(MAX_ID + 1);
    localparam int EW = $clog2(MAX_ID + 2);
    localparam int VW = (EW > ID_W + 1) ? EW : ID_W + 1;
    localparam logic [31:0]   MAX_ID_W  = 32'(MAX_ID);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ID);

    logic [EW-1:0] mem [0:MAX_ID];

    logic [EW-1:0]   mem_rdata_reg;
    logic [AW-1:0]   clr_reg;
    logic [ID_W-1:0] count_reg;
    logic [ID_W-1:0] limit_reg;
    logic [1:0]      cmd_reg;
    logic [ID_W-1:0] id_reg;
    logic [EW-1:0]   nxt_reg;
    logic [EW-1:0]   match_reg;
    logic [EW-1:0]   wval_reg;
    logic [AW-1:0]   waddr_reg;
    logic [AW-1:0]   saddr_reg;
    logic            status_reg;
    logic            is_masked_reg;
    logic [ID_W-1:0] nu_reg;
    logic [ID_W-1:0] nm_reg;

    logic            id_nz;
    logic            in_range;
    logic [AW-1:0]   id_addr;
    logic [EW-1:0]   id_ent;
    logic            masked_now;
    logic            do_mask;
    logic            do_unmask;
    logic [VW-1:0]   nu_cand;
    logic            walk_hit;
    logic [VW-1:0]   scan_p1;
    logic            scan_found;
    logic            scan_last;
    logic [VW-1:0]   clr_p1;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [EW-1:0]   wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;

    always_comb
    begin
        id_nz      = (id_reg != '0);
        in_range   = ({{(32 - ID_W){1'b0}}, id_reg} <= MAX_ID_W);
        id_addr    = AW'(id_reg);
        id_ent     = EW'(id_reg);
        masked_now = id_nz && in_range && (mem_rdata_reg != id_ent);
        do_mask    = (cmd_reg == CMD_MASK) && id_nz && in_range && !masked_now;
        do_unmask  = (cmd_reg == CMD_UNMASK) && masked_now;
        nu_cand    = in_range ? VW'(nxt_reg) : (VW'(id_reg) + VW'(1));
        walk_hit   = (mem_rdata_reg == match_reg);
        scan_p1    = VW'(saddr_reg) + VW'(1);
        scan_found = (VW'(mem_rdata_reg) != scan_p1);
        scan_last  = (saddr_reg == LAST_ADDR);
        clr_p1     = VW'(clr_reg) + VW'(1);

        stat.clr_last  = (clr_reg == LAST_ADDR);
        stat.walk_go   = do_mask || do_unmask;
        stat.walk_more = walk_hit && (waddr_reg != '0);
        stat.scan_skip = !in_range;
        stat.scan_done = scan_found || scan_last;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_data = clr_p1[EW-1:0];
        if (cmd.clr_step)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.walk_step && walk_hit)
        begin
            wr_en   = 1'b1;
            wr_addr = waddr_reg;
            wr_data = wval_reg;
        end

        rd_en   = 1'b0;
        rd_addr = id_addr;
        if (cmd.look_id)
        begin
            rd_en = in_range;
        end
        else if (cmd.look_prev || cmd.walk_start)
        begin
            rd_en   = id_nz && in_range;
            rd_addr = id_addr - AW'(1);
        end
        else if (cmd.walk_step)
        begin
            rd_en   = stat.walk_more;
            rd_addr = waddr_reg - AW'(1);
        end
        else if (cmd.scan_start)
        begin
            rd_en = in_range;
        end
        else if (cmd.scan_step)
        begin
            rd_en   = !stat.scan_done;
            rd_addr = saddr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            count_reg <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.decide)
            begin
                if (do_mask)
                begin
                    count_reg <= count_reg + ID_W'(1);
                end
                else if (do_unmask)
                begin
                    count_reg <= count_reg - ID_W'(1);
                end
            end
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= command;
            id_reg  <= item_id;
        end
        if (cmd.look_prev)
        begin
            nxt_reg <= mem_rdata_reg;
        end
        if (cmd.decide)
        begin
            match_reg     <= do_mask ? id_ent : nxt_reg;
            wval_reg      <= do_mask ? nxt_reg : id_ent;
            status_reg    <= ((cmd_reg == CMD_MASK) || (cmd_reg == CMD_UNMASK)) && !id_nz;
            is_masked_reg <= do_mask || (masked_now && !do_unmask);
            nu_reg        <= (nu_cand > VW'(limit_reg)) ? '0 : nu_cand[ID_W-1:0];
        end
        if (cmd.walk_start)
        begin
            waddr_reg <= id_addr - AW'(1);
        end
        else if (cmd.walk_step && stat.walk_more)
        begin
            waddr_reg <= waddr_reg - AW'(1);
        end
        if (cmd.scan_start)
        begin
            saddr_reg <= id_addr;
            if (!in_range)
            begin
                nm_reg <= '0;
            end
        end
        else if (cmd.scan_step)
        begin
            if (scan_found)
            begin
                nm_reg <= scan_p1[ID_W-1:0];
            end
            else if (scan_last)
            begin
                nm_reg <= '0;
            end
            else
            begin
                saddr_reg <= saddr_reg + AW'(1);
            end
        end
    end

    assign status        = status_reg;
    assign is_masked     = is_masked_reg;
    assign next_unmasked = nu_reg;
    assign next_masked   = nm_reg;
    assign masked_count  = count_reg;

endmodule

[sv/skip_pointer_filter_table.sv]
// Skip-pointer mask table for ids 1 to MAX_ID, held in one single-port-write,
// single-port-read memory of MAX_ID+1 entries.
// A command beat is taken on a rising edge where start is high and busy is low;
// command selects query, mask or unmask of item_id.
// Each beat gives exactly one result beat: result_valid is high for one cycle and
// status, is_masked, next_unmasked, next_masked and masked_count hold its fields.
// The receiver cannot stall; the fields hold until a later command changes them.
// After its command beat a command goes through S_LOOK_ID, S_LOOK_PREV and S_DECIDE;
// when it masks or unmasks an entry, a walk (S_WALK_START, S_WALK) then redirects the
// entries below it whose pointers must change, and a scan (S_SCAN_START, S_SCAN) looks
// for the next masked id in at most MAX_ID+1 entries; it is skipped for an id beyond MAX_ID.
// Both the walk and the scan go through the memory at one entry per cycle, and one
// item is worked on at a time.
// busy is low from the result cycle on, so the next command may come with it.
// cfg_wr_en writes cfg_wr_data into the iterate limit; the user must write it only while the block is idle,
// which the block itself does not enforce. After reset the block clears the table with busy high;
// the mask count is 0 and the limit is 1023.
`include "skip_pointer_filter_table_assert.svh"

module skip_pointer_filter_table #(
    parameter int MAX_ID = 1023
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   command,
    input  logic [spft_pkg::ID_W-1:0]    item_id,
    input  logic                         cfg_wr_en,
    input  logic [spft_pkg::ID_W-1:0]    cfg_wr_data,
    output logic                         result_valid,
    output logic                         status,
    output logic                         is_masked,
    output logic [spft_pkg::ID_W-1:0]    next_unmasked,
    output logic [spft_pkg::ID_W-1:0]    next_masked,
    output logic [spft_pkg::ID_W-1:0]    masked_count
);
    import spft_pkg::*;

    spft_cmd_t  cmd;
    spft_stat_t stat;

    spft_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (result_valid)
    );

    spft_datapath #(
        .MAX_ID (MAX_ID)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .command       (command),
        .item_id       (item_id),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .status        (status),
        .is_masked     (is_masked),
        .next_unmasked (next_unmasked),
        .next_masked   (next_masked),
        .masked_count  (masked_count)
    );

    `SPFT_ASSERT_SAME(a_result_idle, clk, rst_n, result_valid, !busy)
    `SPFT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !result_valid)
    `SPFT_ASSERT_NEXT(a_result_single, clk, rst_n, result_valid, !result_valid)
    `SPFT_ASSERT_SAME(a_error_unmasked, clk, rst_n, result_valid && status, !is_masked)

endmodule
